// ===== rtl/core/ltsu_pkg.sv =====
package ltsu_pkg;

    // Q8.24 signed words
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DT_BITS   = WORD_BITS - 1;

    localparam int CFG_INDEX_BITS = 3;

    localparam int SCRATCH_DEPTH     = 16;
    localparam int SCRATCH_ADDR_BITS = $clog2(SCRATCH_DEPTH);

    localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;

    localparam logic signed [WORD_BITS-1:0] SIGMA_RESET = 32'sd167772160;
    localparam logic signed [WORD_BITS-1:0] RHO_RESET   = 32'sd469762048;
    localparam logic signed [WORD_BITS-1:0] BETA_RESET  = 32'sd44739248;
    localparam logic        [DT_BITS-1:0]   DT_RESET    = 31'd167772;
    localparam logic signed [WORD_BITS-1:0] START_RESET = ONE_Q;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SIGMA   = 3'd0,
        REG_RHO     = 3'd1,
        REG_BETA    = 3'd2,
        REG_DT      = 3'd3,
        REG_START_X = 3'd4,
        REG_START_Y = 3'd5,
        REG_START_Z = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_HALF
    } alu_op_t;

    typedef enum logic [2:0] {
        SRC_MEM,
        SRC_X,
        SRC_Y,
        SRC_Z,
        SRC_SIGMA,
        SRC_RHO,
        SRC_BETA,
        SRC_DT
    } src_t;

    typedef enum logic [1:0] {
        DST_MEM,
        DST_X,
        DST_Y,
        DST_Z
    } dst_t;

    typedef logic [SCRATCH_ADDR_BITS-1:0] saddr_t;

    // scratch slots
    localparam saddr_t S_RZ  = 4'd0;
    localparam saddr_t S_XD  = 4'd1;
    localparam saddr_t S_YD  = 4'd2;
    localparam saddr_t S_ZD  = 4'd3;
    localparam saddr_t S_XDD = 4'd4;
    localparam saddr_t S_YDD = 4'd5;
    localparam saddr_t S_ZDD = 4'd6;
    localparam saddr_t S_H   = 4'd7;
    localparam saddr_t S_T   = 4'd8;
    localparam saddr_t S_U   = 4'd9;
    localparam saddr_t S_NA  = 4'd0;

    typedef struct packed {
        alu_op_t op;
        src_t    a_src;
        saddr_t  a_addr;
        src_t    b_src;
        saddr_t  b_addr;
        dst_t    dst;
        saddr_t  dst_addr;
    } uop_t;

    typedef struct packed {
        logic   rd_en;
        saddr_t rd_addr_a;
        saddr_t rd_addr_b;
        logic   wr_en;
        saddr_t wr_addr;
    } scratch_ctl_t;

    localparam int UOP_COUNT = 33;
    localparam int PC_BITS   = $clog2(UOP_COUNT);
    localparam logic [PC_BITS-1:0] LAST_PC = PC_BITS'(UOP_COUNT - 1);

    function automatic uop_t mk(alu_op_t op, src_t as, saddr_t aa, src_t bs, saddr_t ba,
                                dst_t d, saddr_t da);
        uop_t u;
        u.op       = op;
        u.a_src    = as;
        u.a_addr   = aa;
        u.b_src    = bs;
        u.b_addr   = ba;
        u.dst      = d;
        u.dst_addr = da;
        return u;
    endfunction

    // micro-program: derivatives, second derivatives, then the three updates
    function automatic uop_t uop_at(logic [PC_BITS-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_SUB, SRC_RHO,   S_NA,  SRC_Z,   S_NA,  DST_MEM, S_RZ);
            6'd1:  u = mk(OP_SUB, SRC_Y,     S_NA,  SRC_X,   S_NA,  DST_MEM, S_T);
            6'd2:  u = mk(OP_MUL, SRC_SIGMA, S_NA,  SRC_MEM, S_T,   DST_MEM, S_XD);
            6'd3:  u = mk(OP_MUL, SRC_X,     S_NA,  SRC_MEM, S_RZ,  DST_MEM, S_T);
            6'd4:  u = mk(OP_SUB, SRC_MEM,   S_T,   SRC_Y,   S_NA,  DST_MEM, S_YD);
            6'd5:  u = mk(OP_MUL, SRC_X,     S_NA,  SRC_Y,   S_NA,  DST_MEM, S_T);
            6'd6:  u = mk(OP_MUL, SRC_BETA,  S_NA,  SRC_Z,   S_NA,  DST_MEM, S_U);
            6'd7:  u = mk(OP_SUB, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_MEM, S_ZD);
            6'd8:  u = mk(OP_SUB, SRC_MEM,   S_YD,  SRC_MEM, S_XD,  DST_MEM, S_T);
            6'd9:  u = mk(OP_MUL, SRC_SIGMA, S_NA,  SRC_MEM, S_T,   DST_MEM, S_XDD);
            6'd10: u = mk(OP_MUL, SRC_MEM,   S_XD,  SRC_MEM, S_RZ,  DST_MEM, S_T);
            6'd11: u = mk(OP_MUL, SRC_X,     S_NA,  SRC_MEM, S_ZD,  DST_MEM, S_U);
            6'd12: u = mk(OP_SUB, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_MEM, S_T);
            6'd13: u = mk(OP_SUB, SRC_MEM,   S_T,   SRC_MEM, S_YD,  DST_MEM, S_YDD);
            6'd14: u = mk(OP_MUL, SRC_MEM,   S_XD,  SRC_Y,   S_NA,  DST_MEM, S_T);
            6'd15: u = mk(OP_MUL, SRC_X,     S_NA,  SRC_MEM, S_YD,  DST_MEM, S_U);
            6'd16: u = mk(OP_ADD, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_MEM, S_T);
            6'd17: u = mk(OP_MUL, SRC_BETA,  S_NA,  SRC_MEM, S_ZD,  DST_MEM, S_U);
            6'd18: u = mk(OP_SUB, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_MEM, S_ZDD);
            6'd19: u = mk(OP_MUL, SRC_DT,    S_NA,  SRC_DT,  S_NA,  DST_MEM, S_H);
            6'd20: u = mk(OP_HALF, SRC_MEM,  S_H,   SRC_MEM, S_H,   DST_MEM, S_H);
            6'd21: u = mk(OP_MUL, SRC_DT,    S_NA,  SRC_MEM, S_XD,  DST_MEM, S_T);
            6'd22: u = mk(OP_ADD, SRC_X,     S_NA,  SRC_MEM, S_T,   DST_MEM, S_T);
            6'd23: u = mk(OP_MUL, SRC_MEM,   S_H,   SRC_MEM, S_XDD, DST_MEM, S_U);
            6'd24: u = mk(OP_ADD, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_X,   S_NA);
            6'd25: u = mk(OP_MUL, SRC_DT,    S_NA,  SRC_MEM, S_YD,  DST_MEM, S_T);
            6'd26: u = mk(OP_ADD, SRC_Y,     S_NA,  SRC_MEM, S_T,   DST_MEM, S_T);
            6'd27: u = mk(OP_MUL, SRC_MEM,   S_H,   SRC_MEM, S_YDD, DST_MEM, S_U);
            6'd28: u = mk(OP_ADD, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_Y,   S_NA);
            6'd29: u = mk(OP_MUL, SRC_DT,    S_NA,  SRC_MEM, S_ZD,  DST_MEM, S_T);
            6'd30: u = mk(OP_ADD, SRC_Z,     S_NA,  SRC_MEM, S_T,   DST_MEM, S_T);
            6'd31: u = mk(OP_MUL, SRC_MEM,   S_H,   SRC_MEM, S_ZDD, DST_MEM, S_U);
            6'd32: u = mk(OP_ADD, SRC_MEM,   S_T,   SRC_MEM, S_U,   DST_Z,   S_NA);
            default: u = mk(OP_ADD, SRC_X,   S_NA,  SRC_X,   S_NA,  DST_MEM, S_NA);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/ltsu_if.sv =====
interface ltsu_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ltsu_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ltsu_pkg::WORD_BITS-1:0] out_x;
    logic signed [ltsu_pkg::WORD_BITS-1:0] out_y;
    logic signed [ltsu_pkg::WORD_BITS-1:0] out_z;
    logic                                  overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input overflow, output ready);
endinterface

// ===== rtl/core/lorenz_taylor_step_unit.sv =====
// Channel   Role    Handshake     Payload
// tick      sink    valid/ready   restart
// result    source  valid/ready   out_x, out_y, out_z, overflow
// cfg       write   cfg_wr_en     cfg_index, cfg_wdata
//
// A tick runs 33 micro-ops through the single saturating multiply/add unit, each
// as a scratch read state then an execute state, then loads the output register
// in ST_FINISH. The next tick is taken only once the sequencer is back in idle;
// no new tick is accepted while a step is in progress.
// tick.ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next tick, but a finished step waits in ST_FINISH
// until the previous result beat is taken.
// rst_n clears the sequencer and loads the default gains and state (1.0, 1.0, 1.0).
module lorenz_taylor_step_unit (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic        [ltsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [ltsu_pkg::WORD_BITS-1:0]      cfg_wdata,
    ltsu_tick_if.sink                                  tick,
    ltsu_result_if.source                              result
);

    localparam int W = ltsu_pkg::WORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t                            state_reg;
    logic [ltsu_pkg::PC_BITS-1:0]      pc_reg;
    logic                              flag_reg;
    logic                              out_valid_reg;

    logic signed [W-1:0]               sigma_reg;
    logic signed [W-1:0]               rho_reg;
    logic signed [W-1:0]               beta_reg;
    logic        [ltsu_pkg::DT_BITS-1:0] dt_reg;
    logic signed [W-1:0]               sx_reg;
    logic signed [W-1:0]               sy_reg;
    logic signed [W-1:0]               sz_reg;

    logic signed [W-1:0]               x_reg;
    logic signed [W-1:0]               y_reg;
    logic signed [W-1:0]               z_reg;
    logic signed [W-1:0]               old_x_reg;
    logic signed [W-1:0]               old_y_reg;
    logic signed [W-1:0]               old_z_reg;
    logic signed [W-1:0]               out_x_reg;
    logic signed [W-1:0]               out_y_reg;
    logic signed [W-1:0]               out_z_reg;
    logic                              out_ovf_reg;

    ltsu_pkg::uop_t                    cur_uop;
    ltsu_pkg::scratch_ctl_t            sctl;
    logic signed [W-1:0]               mem_a;
    logic signed [W-1:0]               mem_b;
    logic signed [W-1:0]               opnd_a;
    logic signed [W-1:0]               opnd_b;
    logic signed [W-1:0]               alu_res;
    logic                              alu_ovf;
    logic                              accept;
    logic                              out_free;
    logic                              finish;
    logic signed [W-1:0]               start_x_sel;
    logic signed [W-1:0]               start_y_sel;
    logic signed [W-1:0]               start_z_sel;

    assign accept   = tick.valid && tick.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign finish   = (state_reg == ST_FINISH) && out_free;
    assign cur_uop  = ltsu_pkg::uop_at(pc_reg);

    assign start_x_sel = tick.restart ? sx_reg : x_reg;
    assign start_y_sel = tick.restart ? sy_reg : y_reg;
    assign start_z_sel = tick.restart ? sz_reg : z_reg;

    assign tick.ready      = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.out_x    = out_x_reg;
    assign result.out_y    = out_y_reg;
    assign result.out_z    = out_z_reg;
    assign result.overflow = out_ovf_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= ltsu_pkg::SIGMA_RESET;
            rho_reg   <= ltsu_pkg::RHO_RESET;
            beta_reg  <= ltsu_pkg::BETA_RESET;
            dt_reg    <= ltsu_pkg::DT_RESET;
            sx_reg    <= ltsu_pkg::START_RESET;
            sy_reg    <= ltsu_pkg::START_RESET;
            sz_reg    <= ltsu_pkg::START_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ltsu_pkg::REG_SIGMA:   sigma_reg <= cfg_wdata;
                ltsu_pkg::REG_RHO:     rho_reg   <= cfg_wdata;
                ltsu_pkg::REG_BETA:    beta_reg  <= cfg_wdata;
                ltsu_pkg::REG_DT:      dt_reg    <= cfg_wdata[ltsu_pkg::DT_BITS-1:0];
                ltsu_pkg::REG_START_X: sx_reg    <= cfg_wdata;
                ltsu_pkg::REG_START_Y: sy_reg    <= cfg_wdata;
                ltsu_pkg::REG_START_Z: sz_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    function automatic logic signed [W-1:0] pick(ltsu_pkg::src_t src,
                                                 logic signed [W-1:0] mem_val,
                                                 logic signed [W-1:0] xv,
                                                 logic signed [W-1:0] yv,
                                                 logic signed [W-1:0] zv,
                                                 logic signed [W-1:0] sg,
                                                 logic signed [W-1:0] rh,
                                                 logic signed [W-1:0] bt,
                                                 logic [ltsu_pkg::DT_BITS-1:0] dt);
        logic signed [W-1:0] v;
        case (src)
            ltsu_pkg::SRC_MEM:   v = mem_val;
            ltsu_pkg::SRC_X:     v = xv;
            ltsu_pkg::SRC_Y:     v = yv;
            ltsu_pkg::SRC_Z:     v = zv;
            ltsu_pkg::SRC_SIGMA: v = sg;
            ltsu_pkg::SRC_RHO:   v = rh;
            ltsu_pkg::SRC_BETA:  v = bt;
            ltsu_pkg::SRC_DT:    v = {1'b0, dt};
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign opnd_a = pick(cur_uop.a_src, mem_a, x_reg, y_reg, z_reg,
                         sigma_reg, rho_reg, beta_reg, dt_reg);
    assign opnd_b = pick(cur_uop.b_src, mem_b, x_reg, y_reg, z_reg,
                         sigma_reg, rho_reg, beta_reg, dt_reg);

    always_comb
    begin
        sctl.rd_en     = (state_reg == ST_READ);
        sctl.rd_addr_a = cur_uop.a_addr;
        sctl.rd_addr_b = cur_uop.b_addr;
        sctl.wr_en     = (state_reg == ST_EXEC) && (cur_uop.dst == ltsu_pkg::DST_MEM);
        sctl.wr_addr   = cur_uop.dst_addr;
    end

    ltsu_alu u_alu (
        .op  (cur_uop.op),
        .a   (opnd_a),
        .b   (opnd_b),
        .res (alu_res),
        .ovf (alu_ovf)
    );

    ltsu_scratch u_scratch (
        .clk     (clk),
        .ctl     (sctl),
        .wdata   (alu_res),
        .rdata_a (mem_a),
        .rdata_b (mem_b)
    );

    // sequencer, state vector and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= ltsu_pkg::ONE_Q;
            y_reg         <= ltsu_pkg::ONE_Q;
            z_reg         <= ltsu_pkg::ONE_Q;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg     <= start_x_sel;
                        y_reg     <= start_y_sel;
                        z_reg     <= start_z_sel;
                        pc_reg    <= '0;
                        flag_reg  <= 1'b0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    flag_reg <= flag_reg | alu_ovf;
                    case (cur_uop.dst)
                        ltsu_pkg::DST_X: x_reg <= alu_res;
                        ltsu_pkg::DST_Y: y_reg <= alu_res;
                        ltsu_pkg::DST_Z: z_reg <= alu_res;
                        default: ;
                    endcase
                    if (pc_reg == ltsu_pkg::LAST_PC)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload: state before the step, then the output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_x_reg <= start_x_sel;
            old_y_reg <= start_y_sel;
            old_z_reg <= start_z_sel;
        end
        if (finish)
        begin
            out_x_reg   <= old_x_reg;
            out_y_reg   <= old_y_reg;
            out_z_reg   <= old_z_reg;
            out_ovf_reg <= flag_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick.ready)
        else $error("tick accepted while a step is in progress");

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tick.restart) |=> (x_reg == $past(sx_reg) && y_reg == $past(sy_reg)
                                      && z_reg == $past(sz_reg)))
        else $error("restart did not load start values");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside step completion");

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pc_reg <= ltsu_pkg::LAST_PC))
        else $error("micro-op counter past end of program");

    a_state_hold_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> ($stable(x_reg) && $stable(y_reg) && $stable(z_reg)))
        else $error("state vector changed during scratch read");

endmodule

// ===== rtl/core/ltsu_alu.sv =====
module ltsu_alu (
    input  ltsu_pkg::alu_op_t                     op,
    input  logic signed [ltsu_pkg::WORD_BITS-1:0] a,
    input  logic signed [ltsu_pkg::WORD_BITS-1:0] b,
    output logic signed [ltsu_pkg::WORD_BITS-1:0] res,
    output logic                                  ovf
);

    localparam int W  = ltsu_pkg::WORD_BITS;
    localparam int F  = ltsu_pkg::FRAC_BITS;
    localparam int P  = ltsu_pkg::PROD_BITS;
    localparam int HB = P - (W + F - 1);

    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    logic signed [P-1:0] prod;
    logic        [HB-1:0] prod_hi;
    logic signed [W:0]   sum;
    logic signed [W:0]   diff;

    assign prod    = P'(a) * P'(b);
    assign prod_hi = prod[P-1:W+F-1];
    assign sum     = {a[W-1], a} + {b[W-1], b};
    assign diff    = {a[W-1], a} - {b[W-1], b};

    always_comb
    begin
        res = '0;
        ovf = 1'b0;
        case (op)
            ltsu_pkg::OP_ADD:
            begin
                ovf = sum[W] ^ sum[W-1];
                res = ovf ? (sum[W] ? MIN_W : MAX_W) : sum[W-1:0];
            end
            ltsu_pkg::OP_SUB:
            begin
                ovf = diff[W] ^ diff[W-1];
                res = ovf ? (diff[W] ? MIN_W : MAX_W) : diff[W-1:0];
            end
            ltsu_pkg::OP_MUL:
            begin
                // product shifted down by the fraction width, floor rounding
                ovf = (prod_hi != '0) && (prod_hi != '1);
                res = ovf ? (prod[P-1] ? MIN_W : MAX_W) : prod[W+F-1:F];
            end
            ltsu_pkg::OP_HALF:
            begin
                res = {a[W-1], a[W-1:1]};
            end
            default:
            begin
                res = '0;
                ovf = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ltsu_scratch.sv =====
module ltsu_scratch (
    input  logic                                  clk,
    input  ltsu_pkg::scratch_ctl_t                ctl,
    input  logic signed [ltsu_pkg::WORD_BITS-1:0] wdata,
    output logic signed [ltsu_pkg::WORD_BITS-1:0] rdata_a,
    output logic signed [ltsu_pkg::WORD_BITS-1:0] rdata_b
);

    logic signed [ltsu_pkg::WORD_BITS-1:0] mem [ltsu_pkg::SCRATCH_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_a <= mem[ctl.rd_addr_a];
            rdata_b <= mem[ctl.rd_addr_b];
        end
    end

endmodule
